[hdl/acr_pkg.sv]
// ----------------------------------------------------------------------------
// Audio capture ring package
// Beat layouts, operation codes, register indexes and the sequencer state
// type shared by the capture ring and its testbench.
// ----------------------------------------------------------------------------
`default_nettype none

package acr_pkg;

    // Operation codes carried in the mode field of an input beat.
    localparam logic [1:0] MODE_WRITE  = 2'd0;
    localparam logic [1:0] MODE_ATTACH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_STEREO_CAPTURE = 1'b0;
    localparam logic CFG_RING_FRAMES    = 1'b1;

    // Configuration data is as wide as the widest register.
    localparam int unsigned CFG_DATA_W = 11;

    // Reset values of the configuration registers.
    localparam logic                  STEREO_CAPTURE_RST = 1'b1;
    localparam logic [CFG_DATA_W-1:0] RING_FRAMES_RST    = 11'd1024;

    // One input beat.
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [15:0] left_in;
        logic signed [15:0] right_in;
        logic [1:0]         reader_id;
        logic [5:0]         frame_count;
        logic               want_stereo;
    } t_in_beat;

    // One result beat.
    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
        logic [1:0]         reader_out;
        logic               last_frame;
    } t_out_beat;

    // Read sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_READ
    } t_state;

endpackage

`default_nettype wire

[hdl/acr_ram.sv]
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read that holds its
// data while the read enable is low.
// ----------------------------------------------------------------------------
`default_nettype none

module acr_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

[hdl/audio_capture_ring_multi_reader.sv]
// ----------------------------------------------------------------------------
// Audio capture ring with multiple readers
// Capture frames go into a ring memory; independent readers attach to the
// write pointer and pull bursts of frames back out in mono or stereo format.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (i_valid, o_stall, i_item) carries write, attach and read
// beats. A write stores one frame in the ring memory at the edge it is
// accepted and advances the write pointer; an attach copies the write pointer
// into one reader's pointer. Neither gives a result.
// A read beat starts a burst of frame_count result beats (capped at MAX_READ)
// on the output channel (o_valid, i_stall, o_result). The first frame passes
// through the sequencer state, the ring memory's registered read and the
// output register, then one frame per cycle follows while the receiver takes
// them, set by the single read port of the ring memory. The input stays
// stalled until the last frame of the burst has moved to the output register.
// When the receiver stalls, the output register holds its beat and the memory
// read data is held in place; fetching resumes as soon as the stall drops.
// Reset zeroes all pointers and restores the configuration registers. Ring
// entries never written since reset read as zero, tracked by a fill count, so
// no clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_capture_ring_multi_reader #(
    parameter int unsigned RING_DEPTH = 1024,
    parameter int unsigned READERS    = 4,
    parameter int unsigned MAX_READ   = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // Input channel.
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire acr_pkg::t_in_beat              i_item,
    // Output channel.
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output acr_pkg::t_out_beat                  o_result,
    // Configuration write port.
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_idx,
    input  wire logic [acr_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    import acr_pkg::*;

    localparam int unsigned AW = $clog2(RING_DEPTH);
    localparam int unsigned SW = $clog2(RING_DEPTH + 1);
    localparam int unsigned RW = (READERS > 1) ? $clog2(READERS) : 1;
    localparam int unsigned CW = $clog2(MAX_READ + 1);

    // Configuration registers.
    logic                  r_stereo_capture;
    logic [CFG_DATA_W-1:0] r_ring_frames;

    // Pointers and fill count.
    logic [AW-1:0] r_wpos;
    logic [AW-1:0] r_rpos [READERS];
    logic [SW-1:0] r_fill;

    // Read burst context.
    t_state        r_state;
    t_state        n_state;
    logic [1:0]    r_rid;
    logic [CW-1:0] r_left;
    logic          r_want_stereo;

    // Memory read stage.
    logic          r_rv;
    logic          r_rv_zero;
    logic          r_rv_last;

    // Output register.
    logic          r_ov;
    t_out_beat     r_out;

    // Combinational signals.
    logic          accept;
    logic          do_write;
    logic          start_read;
    logic          issue;
    logic          load;
    logic [31:0]   rf32;
    logic [31:0]   cnt32;
    logic [31:0]   eff_cnt;
    logic [SW-1:0] ring_size;
    logic [RW-1:0] cur_idx;
    logic [RW-1:0] in_idx;
    logic [AW-1:0] raddr;
    logic [SW-1:0] wpos_inc;
    logic [31:0]   ram_wdata;
    logic [31:0]   ram_rdata;
    logic [15:0]   word_lo;
    logic [15:0]   word_hi;

    // Step a pointer by one frame, wrapping at the ring size in use.
    function automatic logic [AW-1:0] advance(input logic [AW-1:0] pos,
                                              input logic [SW-1:0] size);
        logic [SW-1:0] nxt;
        nxt = SW'(pos) + SW'(1);
        if (nxt >= size) begin
            return '0;
        end
        return nxt[AW-1:0];
    endfunction

    // Ring size in use: out-of-range settings fall back to the full depth.
    always_comb begin
        rf32 = 32'(r_ring_frames);
        if (rf32 == 32'd0 || rf32 > RING_DEPTH) begin
            ring_size = SW'(RING_DEPTH);
        end else begin
            ring_size = rf32[SW-1:0];
        end
    end

    // Input handshake and decode.
    assign o_stall    = (r_state != ST_IDLE);
    assign accept     = i_valid && !o_stall;
    assign do_write   = accept && (i_item.mode == MODE_WRITE);
    assign cnt32      = 32'(i_item.frame_count);
    assign eff_cnt    = (cnt32 > MAX_READ) ? 32'(MAX_READ) : cnt32;
    assign start_read = accept && (i_item.mode == MODE_READ)
                        && (32'(i_item.reader_id) < READERS) && (cnt32 != 32'd0);
    assign in_idx     = RW'(32'(i_item.reader_id));
    assign cur_idx    = RW'(32'(r_rid));
    assign wpos_inc   = SW'(r_wpos) + SW'(1);

    // Burst fetch: issue a memory read when the read data stage is free or
    // is being moved to the output register in this cycle.
    assign load  = r_rv && (!r_ov || !i_stall);
    assign issue = (r_state == ST_READ) && (r_left != '0) && (!r_rv || load);
    assign raddr = r_rpos[cur_idx];

    // Stored word layout: left in the low half, right in the high half.
    assign ram_wdata = {r_stereo_capture ? i_item.right_in : 16'sd0, i_item.left_in};

    acr_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_wpos),
        .i_wdata (ram_wdata),
        .i_re    (issue),
        .i_raddr (raddr),
        .o_rdata (ram_rdata)
    );

    // Never-written entries read as zero.
    assign word_lo = r_rv_zero ? 16'd0 : ram_rdata[15:0];
    assign word_hi = r_rv_zero ? 16'd0 : ram_rdata[31:16];

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start_read) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (r_left == '0 && (!r_rv || load)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stereo_capture <= STEREO_CAPTURE_RST;
            r_ring_frames    <= RING_FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEREO_CAPTURE: r_stereo_capture <= i_cfg_data[0];
                CFG_RING_FRAMES:    r_ring_frames    <= i_cfg_data;
                default:            r_ring_frames    <= r_ring_frames;
            endcase
        end
    end

    // Write pointer and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpos <= '0;
            r_fill <= '0;
        end else if (do_write) begin
            r_wpos <= advance(r_wpos, ring_size);
            if (wpos_inc > r_fill) begin
                r_fill <= wpos_inc;
            end
        end
    end

    // Reader pointers: attach loads the write pointer, each fetch advances.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < READERS; i++) begin
                r_rpos[i] <= '0;
            end
        end else if (issue) begin
            r_rpos[cur_idx] <= advance(raddr, ring_size);
        end else if (accept && i_item.mode == MODE_ATTACH
                     && 32'(i_item.reader_id) < READERS) begin
            r_rpos[in_idx] <= r_wpos;
        end
    end

    // Burst context and remaining fetch count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (start_read) begin
            r_left <= CW'(eff_cnt);
        end else if (issue) begin
            r_left <= r_left - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_read) begin
            r_rid         <= i_item.reader_id;
            r_want_stereo <= i_item.want_stereo;
        end
    end

    // Memory read stage flags travel alongside the registered read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rv <= 1'b0;
        end else if (issue) begin
            r_rv <= 1'b1;
        end else if (load) begin
            r_rv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rv_zero <= !(SW'(raddr) < r_fill);
            r_rv_last <= (r_left == CW'(1));
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load) begin
            r_ov <= 1'b1;
        end else if (!i_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out.left_out   <= word_lo;
            r_out.right_out  <= !r_want_stereo   ? 16'sd0  :
                                r_stereo_capture ? word_hi : word_lo;
            r_out.reader_out <= r_rid;
            r_out.last_frame <= r_rv_last;
        end
    end

    assign o_valid  = r_ov;
    assign o_result = r_out;

    // Held read data must not change while it waits for the output register.
    a_rdata_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rv && !load) |=> $stable(ram_rdata))
        else $error("ring read data changed while waiting");

    // Frames are left to fetch only inside a read burst.
    a_left_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_left != '0) |-> (r_state == ST_READ))
        else $error("frames left outside a read burst");

    // The fill count never passes the ring depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fill) <= RING_DEPTH))
        else $error("fill count beyond ring depth");

    // A burst's last fetch is flagged only when one frame remained.
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue |=> (r_rv_last == (r_left == '0)))
        else $error("last frame flag out of step with fetch count");

endmodule

`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the multi-reader audio capture ring
// Drives write, attach, read and unused-mode beats through the valid/stall
// input channel and keeps its own model of the ring memory and its pointers.
// Every frame that leaves the output channel is checked field by field against
// the oldest predicted frame. Both channels idle at random, and the run goes
// through mono and stereo capture and many ring sizes, the extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import acr_pkg::*;

    localparam int unsigned RING_DEPTH   = 1024;
    localparam int unsigned READERS      = 4;
    localparam int unsigned MAX_READ     = 32;
    localparam logic [1:0]  MODE_UNUSED  = 2'd3;
    localparam int unsigned IDLE_PCT     = 11;
    localparam int unsigned DRAIN_CYCLES = 6;
    localparam int unsigned RUN_LIMIT_NS = 2_000_000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    t_in_beat              i_item;
    logic                  o_valid;
    logic                  i_stall;
    t_out_beat             o_result;
    logic                  i_cfg_we;
    logic                  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Model of the ring: memory, pointers and configuration.
    logic [31:0]           ring_mem [RING_DEPTH];
    int unsigned           wr_ptr;
    int unsigned           rd_ptr [READERS];
    logic                  cap_stereo;
    logic [CFG_DATA_W-1:0] ring_len;

    // Frames predicted but not yet seen on the output channel.
    t_out_beat             pending_frames [$];

    // Run statistics and the error tally.
    int unsigned           mismatches;
    int unsigned           frames_checked;
    int unsigned           writes_sent;
    int unsigned           attaches_sent;
    int unsigned           reads_sent;
    int unsigned           cfg_writes;
    bit                    steady;

    audio_capture_ring_multi_reader #(
        .RING_DEPTH (RING_DEPTH),
        .READERS    (READERS),
        .MAX_READ   (MAX_READ)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_item     (i_item),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(RUN_LIMIT_NS);
        $display("tb: failure");
        $finish;
    end

    // Ring size in effect: zero or anything above the memory depth means full depth.
    function automatic int unsigned ring_span();
        if (ring_len == '0 || ring_len > RING_DEPTH) begin
            return RING_DEPTH;
        end
        return ring_len;
    endfunction

    // A pointer steps forward and falls back to zero at or past the ring end.
    function automatic int unsigned next_slot(input int unsigned pos);
        int unsigned nxt;
        nxt = pos + 1;
        if (nxt >= ring_span()) begin
            nxt = 0;
        end
        return nxt;
    endfunction

    function automatic void ring_model_reset();
        for (int i = 0; i < RING_DEPTH; i++) begin
            ring_mem[i] = '0;
        end
        for (int r = 0; r < READERS; r++) begin
            rd_ptr[r] = 0;
        end
        wr_ptr     = 0;
        cap_stereo = STEREO_CAPTURE_RST;
        ring_len   = RING_FRAMES_RST;
    endfunction

    // Apply one accepted beat to the model and queue the frames it reads out.
    function automatic void ring_model_beat(input t_in_beat b);
        int unsigned n;
        logic [31:0] word;
        logic [15:0] hi;
        t_out_beat   f;
        case (b.mode)
            MODE_WRITE: begin
                hi = cap_stereo ? b.right_in : 16'h0000;
                ring_mem[wr_ptr % RING_DEPTH] = {hi, b.left_in};
                wr_ptr = next_slot(wr_ptr);
                writes_sent++;
            end
            MODE_ATTACH: begin
                if (b.reader_id < READERS) begin
                    rd_ptr[b.reader_id] = wr_ptr;
                end
                attaches_sent++;
            end
            MODE_READ: begin
                reads_sent++;
                if (b.reader_id < READERS) begin
                    n = (b.frame_count > MAX_READ) ? MAX_READ : b.frame_count;
                    for (int unsigned k = 0; k < n; k++) begin
                        word         = ring_mem[rd_ptr[b.reader_id] % RING_DEPTH];
                        f.left_out   = word[15:0];
                        if (!b.want_stereo) begin
                            f.right_out = '0;
                        end else if (cap_stereo) begin
                            f.right_out = word[31:16];
                        end else begin
                            f.right_out = word[15:0];
                        end
                        f.reader_out = b.reader_id;
                        f.last_frame = (k + 1 == n);
                        pending_frames.push_back(f);
                        rd_ptr[b.reader_id] = next_slot(rd_ptr[b.reader_id]);
                    end
                end
            end
            default: begin
                // The unused mode changes nothing.
            end
        endcase
    endfunction

    function automatic t_in_beat make_beat(input logic [1:0] mode, input logic [15:0] left,
                                           input logic [15:0] right, input logic [1:0] rid,
                                           input logic [5:0] cnt, input logic stereo);
        t_in_beat b;
        b.mode        = mode;
        b.left_in     = left;
        b.right_in    = right;
        b.reader_id   = rid;
        b.frame_count = cnt;
        b.want_stereo = stereo;
        return b;
    endfunction

    // Random beat; most reads ask for 1..MAX_READ frames, a few for any count.
    function automatic t_in_beat random_beat(input int unsigned write_pct);
        t_in_beat    b;
        int unsigned pick;
        b.left_in     = 16'($urandom);
        b.right_in    = 16'($urandom);
        b.reader_id   = 2'($urandom);
        b.want_stereo = 1'($urandom);
        if ($urandom_range(0, 9) < 8) begin
            b.frame_count = 6'($urandom_range(1, MAX_READ));
        end else begin
            b.frame_count = 6'($urandom_range(0, 63));
        end
        pick = $urandom_range(0, 99);
        if (pick < write_pct) begin
            b.mode = MODE_WRITE;
        end else if (pick < write_pct + 10) begin
            b.mode = MODE_ATTACH;
        end else if (pick < 94) begin
            b.mode = MODE_READ;
        end else begin
            b.mode = MODE_UNUSED;
        end
        return b;
    endfunction

    // Send one beat, with an optional random gap first, and hold it until taken.
    task automatic send_beat(input t_in_beat b);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= b;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        ring_model_beat(b);
    endtask

    // Wait until every predicted frame has come out and the block is idle.
    task automatic drain_ring();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_STEREO_CAPTURE: cap_stereo = data[0];
            CFG_RING_FRAMES:    ring_len   = data;
            default:            ;
        endcase
        cfg_writes++;
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Reads right after reset must return the cleared ring.
    task automatic test_cleared_ring();
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd2, 6'd3, 1'b1));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd3, 6'd2, 1'b0));
        drain_ring();
    endtask

    // Sample extremes, every mode, empty and oversized reads, all readers.
    task automatic test_directed_extremes();
        send_beat(make_beat(MODE_WRITE, 16'h8000, 16'h7FFF, 2'd0, 6'd0, 1'b0));
        send_beat(make_beat(MODE_WRITE, 16'h7FFF, 16'h8000, 2'd0, 6'd0, 1'b0));
        send_beat(make_beat(MODE_WRITE, 16'hFFFF, 16'h0000, 2'd0, 6'd0, 1'b0));
        send_beat(make_beat(MODE_WRITE, 16'h0000, 16'hFFFF, 2'd0, 6'd0, 1'b0));
        send_beat(make_beat(MODE_ATTACH, 16'h0000, 16'h0000, 2'd1, 6'd0, 1'b0));
        send_beat(make_beat(MODE_UNUSED, 16'hA5A5, 16'h5A5A, 2'd3, 6'd63, 1'b1));
        send_beat(make_beat(MODE_READ, 16'hFFFF, 16'hFFFF, 2'd0, 6'd4, 1'b1));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd0, 6'd4, 1'b0));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd1, 6'd0, 1'b1));
        for (int i = 0; i < 4; i++) begin
            send_beat(make_beat(MODE_WRITE, 16'($urandom), 16'($urandom), 2'd0, 6'd0, 1'b0));
        end
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd1, 6'd63, 1'b1));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd2, 6'd33, 1'b0));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd3, 6'd32, 1'b1));
        send_beat(make_beat(MODE_ATTACH, 16'h0000, 16'h0000, 2'd3, 6'd0, 1'b1));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd3, 6'd1, 1'b1));
        drain_ring();
    endtask

    // Mono capture, and slots read back after the capture mode has changed.
    task automatic test_mono_capture();
        t_in_beat b;
        cfg_write(CFG_STEREO_CAPTURE, '0);
        send_beat(make_beat(MODE_ATTACH, 16'h0000, 16'h0000, 2'd2, 6'd0, 1'b0));
        send_beat(make_beat(MODE_ATTACH, 16'h0000, 16'h0000, 2'd3, 6'd0, 1'b0));
        for (int i = 0; i < 6; i++) begin
            b      = random_beat(0);
            b.mode = MODE_WRITE;
            send_beat(b);
        end
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd2, 6'd6, 1'b1));
        drain_ring();
        // Mono-written slots read under stereo capture carry a zero right half.
        cfg_write(CFG_STEREO_CAPTURE, 11'd1);
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd3, 6'd6, 1'b1));
        send_beat(make_beat(MODE_ATTACH, 16'h0000, 16'h0000, 2'd1, 6'd0, 1'b0));
        for (int i = 0; i < 4; i++) begin
            b      = random_beat(0);
            b.mode = MODE_WRITE;
            send_beat(b);
        end
        drain_ring();
        // Stereo-written slots read under mono capture repeat the left sample.
        cfg_write(CFG_STEREO_CAPTURE, '0);
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd1, 6'd2, 1'b1));
        send_beat(make_beat(MODE_READ, 16'h0000, 16'h0000, 2'd1, 6'd2, 1'b0));
        drain_ring();
    endtask

    // Ring sizes: shrinking below live pointers, tiny rings, out-of-range sizes.
    task automatic test_ring_sizes();
        logic [CFG_DATA_W-1:0] sizes [8];
        sizes = '{11'd5, 11'd1, 11'd31, 11'd0, 11'd2047, 11'd1025, 11'd32, 11'd0};
        sizes[7] = 11'($urandom_range(33, RING_DEPTH));
        cfg_write(CFG_STEREO_CAPTURE, 11'd1);
        cfg_write(CFG_RING_FRAMES, 11'd40);
        for (int i = 0; i < 30; i++) begin
            send_beat(random_beat(70));
        end
        drain_ring();
        foreach (sizes[s]) begin
            cfg_write(CFG_RING_FRAMES, sizes[s]);
            for (int i = 0; i < 8; i++) begin
                send_beat(random_beat(55));
            end
            drain_ring();
        end
    endtask

    // Random traffic: one phase with no idling on either side, then mixed settings.
    task automatic test_random_traffic();
        steady = 1'b1;
        cfg_write(CFG_RING_FRAMES, 11'd64);
        for (int i = 0; i < 40; i++) begin
            send_beat(random_beat(50));
        end
        drain_ring();
        steady = 1'b0;
        for (int ph = 0; ph < 3; ph++) begin
            cfg_write(CFG_STEREO_CAPTURE, 11'($urandom_range(0, 1)));
            if (ph == 2) begin
                cfg_write(CFG_RING_FRAMES, 11'd1024);
            end else begin
                cfg_write(CFG_RING_FRAMES, 11'($urandom_range(32, 128)));
            end
            for (int i = 0; i < 14; i++) begin
                send_beat(random_beat(50));
            end
            drain_ring();
        end
    endtask

    // Output side: random stall, and each taken frame checked against the queue.
    initial begin : frame_check
        t_out_beat want;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (pending_frames.size() == 0) begin
                    $display("%0t: frame with none expected: %p", $time, o_result);
                    mismatches++;
                end else begin
                    want = pending_frames.pop_front();
                    frames_checked++;
                    if (o_result.left_out !== want.left_out) begin
                        $display("%0t: left_out expected %h got %h",
                                 $time, want.left_out, o_result.left_out);
                        mismatches++;
                    end
                    if (o_result.right_out !== want.right_out) begin
                        $display("%0t: right_out expected %h got %h",
                                 $time, want.right_out, o_result.right_out);
                        mismatches++;
                    end
                    if (o_result.reader_out !== want.reader_out) begin
                        $display("%0t: reader_out expected %0d got %0d",
                                 $time, want.reader_out, o_result.reader_out);
                        mismatches++;
                    end
                    if (o_result.last_frame !== want.last_frame) begin
                        $display("%0t: last_frame expected %b got %b",
                                 $time, want.last_frame, o_result.last_frame);
                        mismatches++;
                    end
                end
            end
            i_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    // Reset, then the tests in turn.
    initial begin : run_tests
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_STEREO_CAPTURE;
        i_cfg_data = '0;
        ring_model_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_cleared_ring();
        test_directed_extremes();
        test_mono_capture();
        test_ring_sizes();
        test_random_traffic();
        drain_ring();

        $display("tb: %0d writes, %0d attaches, %0d reads sent; %0d frames checked",
                 writes_sent, attaches_sent, reads_sent, frames_checked);
        $display("tb: %0d register writes over mono/stereo capture and ring sizes 0 to 2047",
                 cfg_writes);
        if (mismatches == 0 && pending_frames.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
